[rtl/seven_segment_number_formatter_top_macros.svh]
// assertion macros for the number formatter checker
// expects clk and arst_n in the scope where a macro is used
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_TOP_MACROS_SVH

// same-cycle implication
`define SSNF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssnf check failed");

// next-cycle implication
`define SSNF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssnf check failed");

`endif

[rtl/ssnf_pkg.sv]
// shared constants, types and the power-of-ten table for the number formatter
// no dependencies
package ssnf_pkg;

	localparam int MAX_DIGITS    = 8;
	localparam int FRACTION_BITS = 20;

	localparam int VALUE_W   = 48;
	localparam int PREC_W    = 4;
	localparam int INT_W     = VALUE_W - FRACTION_BITS;
	localparam int POW_W     = 24;
	localparam int NUM_W     = INT_W + POW_W;
	localparam int FPROD_W   = FRACTION_BITS + POW_W;
	localparam int STEP_BITS = 4;
	localparam int CONV_STEPS = (NUM_W + STEP_BITS - 1) / STEP_BITS;
	localparam int CONV_PAD  = CONV_STEPS * STEP_BITS;
	localparam int STEP_CNT_W = $clog2(CONV_STEPS);
	localparam int BCD_W     = 4 * MAX_DIGITS;
	localparam int IDX_W     = $clog2(MAX_DIGITS);
	localparam int EPREC_W   = 3;
	localparam int ADDR_W    = 4;
	localparam int CODE_W    = 8;
	localparam int CNT_W     = 4;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 16;

	localparam logic [3:0]         CODE_MINUS    = 4'hA;
	localparam logic [3:0]         CODE_BLANK    = 4'hF;
	localparam int                 POINT_BIT     = 7;
	localparam logic [CNT_W-1:0]   DEFAULT_COUNT = 4'd4;
	localparam logic [CNT_W-1:0]   MIN_COUNT     = 4'd4;
	localparam logic [PREC_W-1:0]  NEG_PREC_MAX  = 4'd6;
	localparam logic [PREC_W-1:0]  POS_PREC_MAX  = 4'd7;

	typedef struct packed {
		logic load;
		logic mult;
		logic sum;
		logic step;
		logic emit;
	} ssnf_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_digit;
	} ssnf_sts_t;

	function automatic logic [POW_W-1:0] pow10(input logic [EPREC_W-1:0] p);
		logic [POW_W-1:0] r;
		case (p)
			3'd0: r = 24'd1;
			3'd1: r = 24'd10;
			3'd2: r = 24'd100;
			3'd3: r = 24'd1000;
			3'd4: r = 24'd10000;
			3'd5: r = 24'd100000;
			3'd6: r = 24'd1000000;
			3'd7: r = 24'd10000000;
			default: r = 24'd1;
		endcase
		return r;
	endfunction

endpackage

[rtl/seven_segment_number_formatter_top.sv]
// a number is taken while idle, then scaled, summed, bcd converted and written out as digit words
// one digit word per cycle while the output register has room; no new number is taken until
// the last digit word is emitted; the bcd conversion runs 13 steps at 4 bits per cycle
// the last digit word may wait in the output register while the next number is taken
// reset (arst_n low, asynchronous): idle, no word pending, digit_count back to 4
module seven_segment_number_formatter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [ssnf_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // value[47:0], precision[51:48]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [ssnf_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // digit_address[3:0], digit_code[11:4]
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic [ssnf_pkg::CNT_W-1:0]      cfg_wdata      // digit_count
);
	import ssnf_pkg::*;

	ssnf_cmd_t cmd;
	ssnf_sts_t sts;

	ssnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssnf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

[rtl/ssnf_ctrl.sv]
// sequencer for the number formatter: load, scale, sum, bcd conversion, digit writes
// depends on ssnf_pkg
module ssnf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ssnf_pkg::ssnf_sts_t sts,
	output ssnf_pkg::ssnf_cmd_t cmd
);
	import ssnf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MULT = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_CONV = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]            state_q, state_n;
	logic [STEP_CNT_W-1:0] step_q, step_n;

	always_comb begin
		state_n  = state_q;
		step_n   = step_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_MULT;
				end
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_n  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				step_n  = '0;
				state_n = ST_CONV;
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				if (step_q == STEP_CNT_W'(CONV_STEPS - 1)) begin
					state_n = ST_EMIT;
				end else begin
					step_n = step_q + STEP_CNT_W'(1);
				end
			end
			ST_EMIT: begin
				// one digit word per cycle while the output register has room
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_digit) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			step_q  <= step_n;
		end
	end

endmodule

[rtl/ssnf_dp.sv]
// datapath: magnitude, power-of-ten scaling, 4-bit-per-cycle double dabble,
// digit coding with blanking and output register; depends on ssnf_pkg
module ssnf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ssnf_pkg::IN_DATA_W-1:0]    in_data,
	input  logic                              cfg_we,
	input  logic [ssnf_pkg::CNT_W-1:0]        cfg_wdata,
	input  ssnf_pkg::ssnf_cmd_t               cmd,
	output ssnf_pkg::ssnf_sts_t               sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ssnf_pkg::OUT_DATA_W-1:0]   out_data,
	output logic                              out_last
);
	import ssnf_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic [INT_W-1:0]   ipart_q;
	logic [FRACTION_BITS-1:0] fpart_q;
	logic [EPREC_W-1:0] prec_q;
	logic               neg_q;
	logic [NUM_W-1:0]   prod_i_q;
	logic [FPROD_W-1:0] prod_f_q;
	logic [CONV_PAD-1:0] num_q, num_n;
	logic [BCD_W-1:0]   bcd_q, bcd_n;
	logic               ovf_q, ovf_n;
	logic [IDX_W-1:0]   idx_q;
	logic               minus_done_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CODE_W-1:0]  code_q;
	logic               last_q;

	logic [VALUE_W-1:0] in_value;
	logic [PREC_W-1:0]  in_prec;
	logic               in_neg;
	logic [VALUE_W-1:0] in_mag;
	logic [EPREC_W-1:0] in_eprec;
	logic [POW_W-1:0]   pow_sel;
	logic [ADDR_W-1:0]  cur_addr;
	logic               zero_above;
	logic               blank;
	logic [3:0]         nib;
	logic [CODE_W-1:0]  cur_code;
	logic               out_free;

	assign in_value = in_data[VALUE_W-1:0];
	assign in_prec  = in_data[VALUE_W +: PREC_W];
	assign in_neg   = in_value[VALUE_W-1];
	assign in_mag   = in_neg ? (~in_value + VALUE_W'(1)) : in_value;

	always_comb begin
		if (in_neg && (in_prec > NEG_PREC_MAX)) begin
			in_eprec = EPREC_W'(NEG_PREC_MAX);
		end else if (in_prec > POS_PREC_MAX) begin
			in_eprec = '0;
		end else begin
			in_eprec = in_prec[EPREC_W-1:0];
		end
	end

	assign pow_sel = pow10(prec_q);

	// double dabble, STEP_BITS bits of the scaled number per cycle
	always_comb begin
		bcd_n = bcd_q;
		ovf_n = ovf_q;
		num_n = num_q;
		for (int j = 0; j < STEP_BITS; j++) begin
			for (int k = 0; k < MAX_DIGITS; k++) begin
				if (bcd_n[4*k +: 4] >= 4'd5) begin
					bcd_n[4*k +: 4] = bcd_n[4*k +: 4] + 4'd3;
				end
			end
			// a carry out of the top digit means more digits than the display holds
			ovf_n = ovf_n | bcd_n[BCD_W-1];
			bcd_n = {bcd_n[BCD_W-2:0], num_n[CONV_PAD-1]};
			num_n = {num_n[CONV_PAD-2:0], 1'b0};
		end
	end

	assign cur_addr   = ADDR_W'(idx_q) + ADDR_W'(1);
	assign zero_above = !ovf_q && ((bcd_q >> {idx_q, 2'b00}) == '0);
	assign blank      = zero_above && (idx_q > prec_q);
	assign nib        = bcd_q[{idx_q, 2'b00} +: 4];

	always_comb begin
		cur_code = {{(CODE_W-4){1'b0}}, nib};
		if (blank) begin
			cur_code[3:0] = (neg_q && !minus_done_q) ? CODE_MINUS : CODE_BLANK;
		end
		if ((idx_q == prec_q) && (prec_q != '0)) begin
			cur_code[POINT_BIT] = 1'b1;
		end
	end

	assign out_free       = !out_valid_q || out_ready;
	assign sts.out_free   = out_free;
	assign sts.last_digit = (cur_addr == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= DEFAULT_COUNT;
		end else if (cfg_we) begin
			if ((cfg_wdata >= MIN_COUNT) && (cfg_wdata <= CNT_W'(MAX_DIGITS))) begin
				count_q <= cfg_wdata;
			end else begin
				count_q <= DEFAULT_COUNT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			minus_done_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q        <= '0;
				minus_done_q <= 1'b0;
			end else if (cmd.emit) begin
				idx_q <= idx_q + IDX_W'(1);
				if (blank) begin
					minus_done_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ipart_q <= in_mag[VALUE_W-1:FRACTION_BITS];
			fpart_q <= in_mag[FRACTION_BITS-1:0];
			prec_q  <= in_eprec;
			neg_q   <= in_neg;
		end
		if (cmd.mult) begin
			prod_i_q <= NUM_W'(ipart_q) * NUM_W'(pow_sel);
			prod_f_q <= FPROD_W'(fpart_q) * FPROD_W'(pow_sel);
		end
		if (cmd.sum) begin
			num_q <= CONV_PAD'(prod_i_q + NUM_W'(prod_f_q[FPROD_W-1:FRACTION_BITS]));
			bcd_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.step) begin
			num_q <= num_n;
			bcd_q <= bcd_n;
			ovf_q <= ovf_n;
		end
		if (cmd.emit) begin
			addr_q <= cur_addr;
			code_q <= cur_code;
			last_q <= sts.last_digit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {{(OUT_DATA_W-ADDR_W-CODE_W){1'b0}}, code_q, addr_q};
	assign out_last  = last_q;

endmodule

[rtl/ssnf_checker.sv]
// port-level checks for the number formatter, bound to the top level
// depends on ssnf_pkg and seven_segment_number_formatter_top_macros.svh
`include "seven_segment_number_formatter_top_macros.svh"

module ssnf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [ssnf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast
);
	import ssnf_pkg::*;

	logic [ADDR_W-1:0] addr;
	assign addr = m_axis_tdata[ADDR_W-1:0];

	// a stalled word holds
	`SSNF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	// addresses stay within the display
	`SSNF_ASSERT_NOW(a_addr_range, m_axis_tvalid,
		(addr >= ADDR_W'(1)) && (addr <= ADDR_W'(MAX_DIGITS)))
	// the final word sits at a legal digit count
	`SSNF_ASSERT_NOW(a_last_addr, m_axis_tvalid && m_axis_tlast,
		addr >= ADDR_W'(MIN_COUNT))
	// a new number is only taken once all but the final word are out
	`SSNF_ASSERT_NOW(a_in_after_digits, s_axis_tready, !(m_axis_tvalid && !m_axis_tlast))
	// one number at a time
	`SSNF_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind seven_segment_number_formatter_top ssnf_checker u_ssnf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
